### hw/rtl/spr_pkg.sv
// Shared types and constants for the stream pattern replace block.
package spr_pkg;

  localparam int unsigned CFG_W       = 64;  // widest configuration register
  localparam int unsigned LEN_W       = 4;   // length registers and counts
  localparam int unsigned ADDR_W      = 2;   // configuration register index
  localparam int unsigned MAX_LEN_DEF = 8;   // longest pattern / replacement

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_PATTERN     = 2'd0;
  localparam logic [ADDR_W-1:0] REG_PATTERN_LEN = 2'd1;
  localparam logic [ADDR_W-1:0] REG_REPLACE     = 2'd2;
  localparam logic [ADDR_W-1:0] REG_REPLACE_LEN = 2'd3;

  // configuration as seen by the matcher, lengths already clamped
  typedef struct packed {
    logic [CFG_W-1:0] pat;
    logic [LEN_W-1:0] plen;
    logic [CFG_W-1:0] rep;
    logic [LEN_W-1:0] rlen;
  } spr_cfg_t;

  // one input request
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } spr_item_t;

  // control of one burst of results
  typedef struct packed {
    logic [LEN_W-1:0] cnt;       // results in the burst, 1..MAX_LEN
    logic             has_data;  // 0 only for the empty end marker
    logic             fin;       // burst closes the stream
  } spr_burst_t;

endpackage

### hw/rtl/spr_cfg.sv
// Configuration registers with length clamping.
module spr_cfg #(
  parameter int unsigned MAX_LEN = spr_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [spr_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [spr_pkg::CFG_W-1:0]   cfg_data,
  output spr_pkg::spr_cfg_t           cfg,
  output logic                        clr_fill
);

  logic [spr_pkg::CFG_W-1:0] pattern;
  logic [spr_pkg::LEN_W-1:0] pattern_len;
  logic [spr_pkg::CFG_W-1:0] replace;
  logic [spr_pkg::LEN_W-1:0] replace_len;

  localparam logic [spr_pkg::LEN_W-1:0] MaxLen = spr_pkg::LEN_W'(MAX_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= '0;
      pattern_len <= spr_pkg::LEN_W'(1);
      replace     <= '0;
      replace_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        spr_pkg::REG_PATTERN:     pattern     <= cfg_data;
        spr_pkg::REG_PATTERN_LEN: pattern_len <= cfg_data[spr_pkg::LEN_W-1:0];
        spr_pkg::REG_REPLACE:     replace     <= cfg_data;
        spr_pkg::REG_REPLACE_LEN: replace_len <= cfg_data[spr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // new pattern length drops whatever the window holds
  assign clr_fill = cfg_we && (cfg_addr == spr_pkg::REG_PATTERN_LEN);

  always_comb begin
    cfg.pat  = pattern;
    cfg.rep  = replace;
    if (pattern_len == '0)        cfg.plen = spr_pkg::LEN_W'(1);
    else if (pattern_len > MaxLen) cfg.plen = MaxLen;
    else                          cfg.plen = pattern_len;
    cfg.rlen = (replace_len > MaxLen) ? MaxLen : replace_len;
  end

endmodule

### hw/rtl/spr_in_skid.sv
// Input register with skid entry; ready is a plain flop.
module spr_in_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  spr_pkg::spr_item_t in_item,
  output logic               item_valid,
  output spr_pkg::spr_item_t item,
  input  logic               item_take
);

  logic               main_v;
  logic               skid_v;
  spr_pkg::spr_item_t skid;
  logic               accept;

  assign s_tready   = !skid_v;
  assign accept     = s_tvalid && !skid_v;
  assign item_valid = main_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (main_v && item_take) begin
      if (skid_v) begin
        item   <= skid;
        skid_v <= 1'b0;
      end else if (accept) begin
        item <= in_item;
      end else begin
        main_v <= 1'b0;
      end
    end else if (accept) begin
      if (!main_v) begin
        item   <= in_item;
        main_v <= 1'b1;
      end else begin
        skid   <= in_item;
        skid_v <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/spr_core.sv
// Match window, pattern compare and result selection for one request.
module spr_core #(
  parameter int unsigned MAX_LEN = spr_pkg::MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spr_pkg::spr_cfg_t    cfg,
  input  logic                 clr_fill,
  input  logic                 item_valid,
  input  spr_pkg::spr_item_t   item,
  input  logic                 emit_ready,
  output logic                 item_take,
  output logic                 burst_load,
  output spr_pkg::spr_burst_t  burst,
  output logic [MAX_LEN*8-1:0] burst_bytes
);

  localparam int unsigned LW = spr_pkg::LEN_W;

  logic [7:0]    win     [MAX_LEN];
  logic [7:0]    win_w   [MAX_LEN];
  logic [7:0]    win_s   [MAX_LEN];
  logic [LW-1:0] fill;
  logic [LW-1:0] fill0;
  logic [LW-1:0] fill1;
  logic [LW-1:0] fill_next;
  logic [LW-1:0] n;
  logic          full;
  logic          hit;
  logic          marker;

  assign item_take = item_valid && emit_ready;

  always_comb begin
    fill0 = (fill >= cfg.plen) ? '0 : fill;
    fill1 = fill0 + LW'(1);
    full  = (fill1 == cfg.plen);

    for (int k = 0; k < MAX_LEN; k++) begin
      win_w[k] = (LW'(k) == fill0) ? item.data : win[k];
    end
    for (int k = 0; k < MAX_LEN; k++) begin
      win_s[k] = (k < MAX_LEN - 1) ? win_w[(k + 1) % MAX_LEN] : win_w[k];
    end

    hit = 1'b1;
    for (int k = 0; k < MAX_LEN; k++) begin
      if ((LW'(k) < cfg.plen) && (win_w[k] != cfg.pat[k*8 +: 8])) hit = 1'b0;
    end

    // results: replacement on a hit, oldest byte on a miss, whole window on flush
    if (full && hit)  n = cfg.rlen;
    else if (full)    n = item.fin ? cfg.plen : LW'(1);
    else              n = item.fin ? fill1 : '0;
    marker = item.fin && (n == '0);

    if (item.fin || (full && hit)) fill_next = '0;
    else if (full)                 fill_next = cfg.plen - LW'(1);
    else                           fill_next = fill1;

    burst.cnt      = marker ? LW'(1) : n;
    burst.has_data = !marker;
    burst.fin      = item.fin;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (marker)           burst_bytes[k*8 +: 8] = '0;
      else if (full && hit) burst_bytes[k*8 +: 8] = cfg.rep[k*8 +: 8];
      else                  burst_bytes[k*8 +: 8] = win_w[k];
    end
    burst_load = item_take && (n != '0 || marker);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (clr_fill) begin
      fill <= '0;
    end else if (item_take) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      for (int k = 0; k < MAX_LEN; k++) begin
        win[k] <= (full && !hit) ? win_s[k] : win_w[k];
      end
    end
  end

endmodule

### hw/rtl/spr_emit.sv
// Burst register; sends one result per cycle while m_tready is high, oldest byte first.
module spr_emit #(
  parameter int unsigned MAX_LEN = spr_pkg::MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 burst_load,
  input  spr_pkg::spr_burst_t  burst,
  input  logic [MAX_LEN*8-1:0] burst_bytes,
  output logic                 emit_ready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  output logic [1:0]           m_tuser
);

  localparam int unsigned LW = spr_pkg::LEN_W;

  logic                 b_valid;
  spr_pkg::spr_burst_t  ctl;
  logic [MAX_LEN*8-1:0] bytes;
  logic                 last;

  assign last       = (ctl.cnt == LW'(1));
  assign emit_ready = !b_valid || (last && m_tready);

  assign m_tvalid = b_valid;
  assign m_tdata  = bytes[7:0];
  assign m_tlast  = last;
  assign m_tuser  = {last && ctl.fin, ctl.has_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (burst_load) begin
      b_valid <= 1'b1;
    end else if (b_valid && m_tready && last) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      ctl   <= burst;
      bytes <= burst_bytes;
    end else if (b_valid && m_tready) begin
      ctl.cnt <= ctl.cnt - LW'(1);
      bytes   <= bytes >> 8;
    end
  end

endmodule

### hw/rtl/stream_pattern_replace.sv
// Top level of the streaming find-and-replace block.
//
// Usage: configure the pattern (1..MAX_LEN bytes) and the replacement
// (0..MAX_LEN bytes) through the cfg_* write port while the block is idle,
// then stream bytes in on s_* (tdata = byte, tlast = final byte of the stream).
// Every leftmost, non-overlapping occurrence of the pattern comes out on m_*
// replaced; tlast marks the last result of one request, tuser[0] says the
// byte is real (0 only on the empty end marker), tuser[1] marks stream end.
// A request that yields zero or one result lets the next one through as soon
// as the burst register can take it; one that yields n results (replacement or
// final flush) holds the burst register until all n are sent, and the input
// side waits on it once its skid entry is full.
// s_tready comes straight from a flop (skid entry empty), so it never
// depends on m_tready combinationally.
// Reset (rst, synchronous) empties the pipeline and the window and restores
// pattern length 1, replacement length 0. Writing the pattern length drops
// any bytes the window holds.
// Receiver stall: results hold on m_*, the input skid fills, then s_tready
// drops until the burst drains.
module stream_pattern_replace #(
  parameter int unsigned MAX_LEN = spr_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [spr_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [spr_pkg::CFG_W-1:0]  cfg_data,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] in_byte
  input  logic                       s_tlast,   // in_final
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [7:0] out_byte
  output logic                       m_tlast,   // run_last
  output logic [1:0]                 m_tuser    // [0] byte_valid, [1] stream_end
);

  spr_pkg::spr_cfg_t    cfg;
  logic                 clr_fill;
  spr_pkg::spr_item_t   in_item;
  spr_pkg::spr_item_t   item;
  logic                 item_valid;
  logic                 item_take;
  logic                 emit_ready;
  logic                 burst_load;
  spr_pkg::spr_burst_t  burst;
  logic [MAX_LEN*8-1:0] burst_bytes;

  assign in_item.data = s_tdata;
  assign in_item.fin  = s_tlast;

  spr_cfg #(.MAX_LEN(MAX_LEN)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .clr_fill (clr_fill)
  );

  // input request register plus one skid entry
  spr_in_skid u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // window update and burst selection, one request per cycle while the burst register can take it
  spr_core #(.MAX_LEN(MAX_LEN)) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clr_fill    (clr_fill),
    .item_valid  (item_valid),
    .item        (item),
    .emit_ready  (emit_ready),
    .item_take   (item_take),
    .burst_load  (burst_load),
    .burst       (burst),
    .burst_bytes (burst_bytes)
  );

  // burst register drained one byte per accepted output request
  spr_emit #(.MAX_LEN(MAX_LEN)) u_emit (
    .clk         (clk),
    .rst         (rst),
    .burst_load  (burst_load),
    .burst       (burst),
    .burst_bytes (burst_bytes),
    .emit_ready  (emit_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

  // stream end can only close a run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("stream_end without run_last");

  // empty marker is a lone zero byte that ends the stream
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && (m_tdata == 8'd0))
    else $error("malformed end marker");

  // skid entry only fills behind a full input register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> item_valid)
    else $error("skid entry full while input register empty");

  // the burst register is only loaded from a consumed request, while it can take one
  a_take_ready: assert property (@(posedge clk) disable iff (rst)
    burst_load |-> item_take && emit_ready)
    else $error("burst loaded without a consumed request");

endmodule

### dv/tb_stream_pattern_replace.sv
// Self-checking testbench for stream_pattern_replace: directed table, then random streams.
`timescale 1ns / 100ps

module tb_stream_pattern_replace;

  localparam int          PREDICTED        = -1;     // row result comes from the predictor
  localparam int unsigned RAND_ITEMS       = 450;
  localparam int unsigned DRAIN_CYCLES     = 8;      // covers the input and burst registers plus margin
  localparam int unsigned LONG_HOLD_AT     = 150;    // requests accepted before the long stall
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT      = 300000;

  // one result as the block reports it
  typedef struct packed {
    logic [7:0] data;   // out_byte
    logic       valid;  // byte_valid
    logic       last;   // run_last
    logic       send;   // stream_end
  } byte_rec_t;

  typedef enum bit {ROW_WRITE, ROW_BYTE} row_kind_t;

  // directed stimulus row: a register write or one request
  typedef struct {
    row_kind_t                  kind;
    logic [spr_pkg::ADDR_W-1:0] addr;
    logic [spr_pkg::CFG_W-1:0]  data;
    logic [7:0]                 b;
    logic                       fin;
    int                         typed_n;  // PREDICTED, or 0/1 results typed in below
    byte_rec_t                  typed;
  } stim_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [spr_pkg::ADDR_W-1:0] cfg_addr;
  logic [spr_pkg::CFG_W-1:0]  cfg_data;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [7:0]                 s_tdata;
  logic                       s_tlast;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [7:0]                 m_tdata;
  logic                       m_tlast;
  logic [1:0]                 m_tuser;

  stream_pattern_replace uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] in_byte
    .s_tlast  (s_tlast),   // in_final
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] out_byte
    .m_tlast  (m_tlast),   // run_last
    .m_tuser  (m_tuser)    // [0] byte_valid, [1] stream_end
  );

  // ---------------------------------------------------------------------------
  // Predictor state: registers as written, plus the match window
  // ---------------------------------------------------------------------------
  logic [spr_pkg::CFG_W-1:0] pat_bytes;
  logic [3:0]                pat_len_reg;
  logic [spr_pkg::CFG_W-1:0] rep_bytes;
  logic [3:0]                rep_len_reg;
  logic [7:0]                win [spr_pkg::MAX_LEN_DEF];
  int unsigned               win_fill;

  byte_rec_t   new_bytes[$];       // results of the latest request
  byte_rec_t   expected_bytes[$];  // results still owed by the block
  stim_row_t   stim_table[$];
  int unsigned burst_left;
  int unsigned accepted_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  byte_rec_t   got_rec;
  byte_rec_t   want_rec;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // effective pattern length: zero reads as one, above MAX_LEN saturates
  function automatic int unsigned eff_pat_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > spr_pkg::MAX_LEN_DEF) return spr_pkg::MAX_LEN_DEF;
    return pat_len_reg;
  endfunction

  task automatic apply_write(input logic [spr_pkg::ADDR_W-1:0] a,
                             input logic [spr_pkg::CFG_W-1:0] d);
    case (a)
      spr_pkg::REG_PATTERN:     pat_bytes = d;
      spr_pkg::REG_PATTERN_LEN: begin
        pat_len_reg = d[3:0];
        win_fill    = 0;  // window dropped on a length write, even mid-stream
      end
      spr_pkg::REG_REPLACE:     rep_bytes = d;
      spr_pkg::REG_REPLACE_LEN: rep_len_reg = d[3:0];
      default: ;
    endcase
  endtask

  // Runs one request through the window and leaves its results in new_bytes.
  task automatic rewrite_byte(input logic [7:0] b, input logic fin);
    int unsigned plen;
    int unsigned rlen;
    int unsigned k;
    bit          hit;
    byte_rec_t   tail;
    plen = eff_pat_len();
    rlen = (rep_len_reg > spr_pkg::MAX_LEN_DEF) ? spr_pkg::MAX_LEN_DEF : rep_len_reg;
    new_bytes.delete();
    if (win_fill >= plen) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill == plen) begin
      hit = 1'b1;
      for (k = 0; k < plen; k++)
        if (win[k] != pat_bytes[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        for (k = 0; k < rlen; k++)
          new_bytes.push_back('{rep_bytes[8*k +: 8], 1'b1, 1'b0, 1'b0});
        win_fill = 0;
      end else begin
        // full window, no match: oldest byte leaves
        new_bytes.push_back('{win[0], 1'b1, 1'b0, 1'b0});
        for (k = 1; k < plen; k++) win[k-1] = win[k];
        win_fill--;
      end
    end
    if (fin) begin
      for (k = 0; k < win_fill; k++) new_bytes.push_back('{win[k], 1'b1, 1'b0, 1'b0});
      win_fill = 0;
      // nothing left on the final byte: empty end marker
      if (new_bytes.size() == 0) new_bytes.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
    end
    if (new_bytes.size() != 0) begin
      tail      = new_bytes.pop_back();
      tail.last = 1'b1;
      tail.send = fin;
      new_bytes.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_write(input logic [spr_pkg::ADDR_W-1:0] a,
                           input logic [spr_pkg::CFG_W-1:0] d);
    stim_table.push_back('{ROW_WRITE, a, d, 8'h00, 1'b0, 0, '0});
  endtask

  task automatic add_byte(input logic [7:0] b, input logic fin, input int typed_n,
                          input byte_rec_t typed);
    stim_table.push_back('{ROW_BYTE, spr_pkg::REG_PATTERN, '0, b, fin, typed_n, typed});
  endtask

  // Register write, taken at the next rising edge; cfg_we stays up for back-to-back writes.
  task automatic write_reg(input logic [spr_pkg::ADDR_W-1:0] a,
                           input logic [spr_pkg::CFG_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
    apply_write(a, d);
  endtask

  // Sender: bursts of random length with random gaps, then wait for the handshake.
  task automatic send_byte(input logic [7:0] b, input logic fin, input int typed_n,
                           input byte_rec_t typed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    accepted_cnt <= accepted_cnt + 1;
    rewrite_byte(b, fin);
    if (typed_n == PREDICTED) begin
      foreach (new_bytes[i]) expected_bytes.push_back(new_bytes[i]);
    end else if (typed_n == 1) begin
      expected_bytes.push_back(typed);
    end
  endtask

  // Drain before a register write; requests that give no result may still be in flight.
  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_rec = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h byte_valid %0b", m_tdata, m_tuser[0]);
        err_cnt++;
      end else begin
        want_rec = expected_bytes.pop_front();
        if (got_rec.data !== want_rec.data) begin
          $error("out_byte: expected %02h, got %02h", want_rec.data, got_rec.data);
          err_cnt++;
        end
        if (got_rec.valid !== want_rec.valid) begin
          $error("byte_valid: expected %0b, got %0b", want_rec.valid, got_rec.valid);
          err_cnt++;
        end
        if (got_rec.last !== want_rec.last) begin
          $error("run_last: expected %0b, got %0b", want_rec.last, got_rec.last);
          err_cnt++;
        end
        if (got_rec.send !== want_rec.send) begin
          $error("stream_end: expected %0b, got %0b", want_rec.send, got_rec.send);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern re-picked at random after a random run, plus one long
  // hold-off so the block fills up and drops s_tready while requests keep coming
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned mode;
    bit          hold_done;
    m_tready  = 1'b0;
    mode_left = 0;
    hold_left = 0;
    mode      = 0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && accepted_cnt >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((mode_left % 8) < 5);
        endcase
      end
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit                        in_cfg;
    int unsigned               rand_items;
    int unsigned               n_streams;
    int unsigned               tlen;
    int unsigned               pick;
    int unsigned               plen_now;
    int unsigned               k;
    bit                        keep_open;
    logic [7:0]                fill_b;
    logic [7:0]                text[$];
    logic [spr_pkg::CFG_W-1:0] pat_v;
    logic [spr_pkg::CFG_W-1:0] plen_d;
    logic [spr_pkg::CFG_W-1:0] rlen_d;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tlast      = 1'b0;
    pat_bytes    = '0;
    pat_len_reg  = 4'd1;
    rep_bytes    = '0;
    rep_len_reg  = 4'd0;
    win_fill     = 0;
    foreach (win[i]) win[i] = 8'h00;
    burst_left   = 0;
    accepted_cnt = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    in_cfg       = 1'b0;

    // After reset: pattern 00, length 1, replacement empty
    add_byte(8'h00, 1'b0, 0, '0);                          // match, deleted: no result
    add_byte(8'hFF, 1'b1, 1, '{8'hFF, 1'b1, 1'b1, 1'b1});  // miss on final byte
    add_byte(8'h00, 1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1});  // deleted on final: end marker
    // "abc" -> "XY"
    add_write(spr_pkg::REG_PATTERN, 64'h0000_0000_0063_6261);
    add_write(spr_pkg::REG_PATTERN_LEN, 64'd3);
    add_write(spr_pkg::REG_REPLACE, 64'h0000_0000_0000_5958);
    add_write(spr_pkg::REG_REPLACE_LEN, 64'd2);
    add_byte("c", 1'b0, PREDICTED, '0);
    add_byte("a", 1'b0, PREDICTED, '0);
    add_byte("b", 1'b0, PREDICTED, '0);
    add_byte("c", 1'b0, PREDICTED, '0);
    add_byte("a", 1'b0, PREDICTED, '0);
    add_byte("b", 1'b1, PREDICTED, '0);
    // length rewritten while "ab" sits in the window: those bytes are dropped
    add_byte("a", 1'b0, 0, '0);
    add_byte("b", 1'b0, 0, '0);
    add_write(spr_pkg::REG_PATTERN_LEN, 64'd3);
    add_byte("c", 1'b1, 1, '{8'h63, 1'b1, 1'b1, 1'b1});
    // zero pattern length reads as one; replacement length saturates at 8
    add_write(spr_pkg::REG_PATTERN, 64'h0000_0000_0000_00FF);
    add_write(spr_pkg::REG_PATTERN_LEN, 64'd0);
    add_write(spr_pkg::REG_REPLACE, 64'h8899_AABB_CCDD_EEF0);
    add_write(spr_pkg::REG_REPLACE_LEN, 64'd15);
    add_byte(8'hFF, 1'b0, PREDICTED, '0);
    add_byte(8'h00, 1'b1, 1, '{8'h00, 1'b1, 1'b1, 1'b1});
    // pattern length saturates at 8; full 8-byte match deleted on the final byte
    add_write(spr_pkg::REG_PATTERN, 64'h0807_0605_0403_0201);
    add_write(spr_pkg::REG_PATTERN_LEN, 64'd15);
    add_write(spr_pkg::REG_REPLACE_LEN, 64'd0);
    for (k = 1; k < 8; k++) add_byte(8'(k), 1'b0, 0, '0);
    add_byte(8'h08, 1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1});
    add_byte(8'h80, 1'b1, 1, '{8'h80, 1'b1, 1'b1, 1'b1});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        if (!in_cfg) wait_idle();
        write_reg(stim_table[i].addr, stim_table[i].data);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) begin
          cfg_we <= 1'b0;
          in_cfg = 1'b0;
        end
        send_byte(stim_table[i].b, stim_table[i].fin, stim_table[i].typed_n,
                  stim_table[i].typed);
      end
    end

    // Random phases: new settings, then a few streams built around the pattern
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 2))
        0: pat_v = {$urandom, $urandom};
        1: for (k = 0; k < 8; k++) pat_v[8*k +: 8] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
        default: begin
          fill_b = 8'($urandom_range(0, 255));
          pat_v  = {8{fill_b}};
        end
      endcase
      // length data may carry junk above bit 3; only the low nibble counts
      plen_d = {$urandom, $urandom};
      rlen_d = {$urandom, $urandom};
      if ($urandom_range(0, 1)) plen_d[spr_pkg::CFG_W-1:4] = '0;
      if ($urandom_range(0, 1)) rlen_d[spr_pkg::CFG_W-1:4] = '0;
      pick = $urandom_range(0, 9);
      plen_d[3:0] = (pick == 0) ? 4'd0 : (pick == 1) ? 4'($urandom_range(9, 15))
                                                      : 4'($urandom_range(1, 8));
      rlen_d[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
      write_reg(spr_pkg::REG_PATTERN, pat_v);
      write_reg(spr_pkg::REG_PATTERN_LEN, plen_d);
      write_reg(spr_pkg::REG_REPLACE, {$urandom, $urandom});
      write_reg(spr_pkg::REG_REPLACE_LEN, rlen_d);
      cfg_we <= 1'b0;

      plen_now  = eff_pat_len();
      n_streams = $urandom_range(2, 6);
      for (int s = 0; s < n_streams; s++) begin
        tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        text.delete();
        while (text.size() < tlen) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            for (k = 0; k < plen_now; k++) text.push_back(pat_bytes[8*k +: 8]);
          end else if (pick < 8) begin
            // single pattern byte: near misses and overlapping prefixes
            text.push_back(pat_bytes[8*$urandom_range(0, plen_now - 1) +: 8]);
          end else begin
            text.push_back(8'($urandom_range(0, 255)));
          end
        end
        // last stream of a phase sometimes stays open across the next length write
        keep_open = (s == n_streams - 1) && ($urandom_range(0, 2) == 0);
        foreach (text[j])
          send_byte(text[j], (j == text.size() - 1) && !keep_open, PREDICTED, '0);
        rand_items += text.size();
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
